// ===== hw/rtl/cld_pkg.sv =====
// Package for the circular list deque: sizes, operation and status codes, cell types.
package cld_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_DUMP       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Command broadcast to every cell in the row
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_ROTATE
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [DATA_W-1:0]  push_val;
        logic signed [DATA_W-1:0]  front_val;
    } t_cell_ctl;

    // What one cell shows its neighbors
    typedef struct packed {
        logic                      valid;
        logic signed [DATA_W-1:0]  value;
    } t_tap;

endpackage

// ===== hw/rtl/cld_cell.sv =====
// One storage cell of the deque row: holds an entry and its valid bit.
module cld_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cld_pkg::t_cell_ctl i_ctl,
    input  cld_pkg::t_tap      i_left,
    input  cld_pkg::t_tap      i_right,
    output cld_pkg::t_tap      o_tap
);
    import cld_pkg::*;

    logic                      r_valid;
    logic signed [DATA_W-1:0]  r_value;
    logic                      n_valid;
    logic signed [DATA_W-1:0]  n_value;
    logic                      w_is_back;

    // Back entry: valid with nothing valid behind it
    assign w_is_back = r_valid && !i_right.valid;

    // Next entry per command
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        case (i_ctl.cmd)
            CMD_PUSH_FRONT: begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end
            CMD_PUSH_BACK: begin
                if (!r_valid && i_left.valid) begin
                    n_valid = 1'b1;
                    n_value = i_ctl.push_val;
                end
            end
            CMD_POP_FRONT: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
            end
            CMD_POP_BACK: begin
                if (w_is_back) begin
                    n_valid = 1'b0;
                end
            end
            CMD_ROTATE: begin
                // front entry wraps to the back slot
                if (w_is_back) begin
                    n_value = i_ctl.front_val;
                end else if (r_valid) begin
                    n_value = i_right.value;
                end
            end
            default: begin
                n_valid = r_valid;
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_tap.valid = r_valid;
    assign o_tap.value = r_value;

endmodule

// ===== hw/rtl/circular_list_deque.sv =====
// Top level of the circular list deque: request control, cell row and result register.
// Bounded deque of DEPTH signed 32-bit entries kept in a row of cells, front in cell 0.
// Push front/back, pop front/back and unused op codes give one result each, without a walk.
// Remove-by-value and dump walk the row: each cycle the result register is free, the front
// entry is compared or reported and either wrapped to the back or dropped, one step per
// stored entry, and they leave the order intact; a dump gives one result per entry, last on
// the back one.
// An empty-list dump or remove answers without a walk. The walk and new requests wait whenever
// the result register is full and not being taken.
module circular_list_deque (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_op,
    input  logic signed [cld_pkg::DATA_W-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic signed [cld_pkg::DATA_W-1:0] o_item_value,
    output logic                             o_last
);
    import cld_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state                    r_state;
    logic                      r_is_dump;
    logic                      r_found;
    logic signed [DATA_W-1:0]  r_key;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_left;
    logic                      r_out_valid;
    t_status                   r_status;
    logic signed [DATA_W-1:0]  r_item;
    logic                      r_last;

    t_state                    n_state;
    logic                      n_is_dump;
    logic                      n_found;
    logic signed [DATA_W-1:0]  n_key;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          n_left;
    logic                      n_emit;
    t_status                   n_status;
    logic signed [DATA_W-1:0]  n_item;
    logic                      n_last;

    t_cell_ctl                 w_ctl;
    t_tap                      w_tap [DEPTH];
    logic [DEPTH-1:0]          w_valid;
    logic                      w_out_free;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_match;
    logic                      w_final;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = w_tap[DEPTH-1].valid;
    assign w_empty    = !w_tap[0].valid;
    assign w_match    = !r_found && (w_tap[0].value == r_key);
    assign w_final    = (r_left == CNT_W'(1));

    // Request decode and walk sequencing
    always_comb begin
        n_state   = r_state;
        n_is_dump = r_is_dump;
        n_found   = r_found;
        n_key     = r_key;
        n_count   = r_count;
        n_left    = r_left;
        n_emit    = 1'b0;
        n_status  = ST_OK;
        n_item    = '0;
        n_last    = 1'b1;
        w_ctl.cmd       = CMD_HOLD;
        w_ctl.push_val  = i_value;
        w_ctl.front_val = w_tap[0].value;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_emit = 1'b1;
                    case (i_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.cmd = (i_op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                    : CMD_PUSH_BACK;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctl.cmd = (i_op == OP_POP_FRONT) ? CMD_POP_FRONT
                                                                   : CMD_POP_BACK;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_REMOVE, OP_DUMP: begin
                            if (w_empty) begin
                                n_status = (i_op == OP_DUMP) ? ST_EMPTY : ST_NOT_FOUND;
                            end else begin
                                n_emit    = 1'b0;
                                n_state   = S_WALK;
                                n_is_dump = (i_op == OP_DUMP);
                                n_found   = 1'b0;
                                n_key     = i_value;
                                n_left    = r_count;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_out_free) begin
                    n_left = r_left - CNT_W'(1);
                    if (r_is_dump) begin
                        w_ctl.cmd = CMD_ROTATE;
                        n_emit    = 1'b1;
                        n_item    = w_tap[0].value;
                        n_last    = w_final;
                    end else begin
                        if (w_match) begin
                            w_ctl.cmd = CMD_POP_FRONT;
                            n_found   = 1'b1;
                            n_count   = r_count - CNT_W'(1);
                        end else begin
                            w_ctl.cmd = CMD_ROTATE;
                        end
                        n_emit   = w_final;
                        n_status = (r_found || w_match) ? ST_OK : ST_NOT_FOUND;
                    end
                    if (w_final) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_is_dump   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_found   <= n_found;
            r_is_dump <= n_is_dump;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_key <= n_key;
        if (n_emit) begin
            r_status <= n_status;
            r_item   <= n_item;
            r_last   <= n_last;
        end
    end

    // Row of cells, front at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_tap w_left;
        t_tap w_right;
        if (g == 0) begin : g_first
            assign w_left.valid = 1'b1;
            assign w_left.value = i_value;
        end else begin : g_mid
            assign w_left = w_tap[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign w_right.valid = 1'b0;
            assign w_right.value = '0;
        end else begin : g_inner
            assign w_right = w_tap[g+1];
        end
        cld_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_tap   (w_tap[g])
        );
        assign w_valid[g] = w_tap[g].valid;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_item_value = r_item;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    // Occupancy counter tracks the valid cells
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_valid)))
        else $error("occupancy count differs from valid cells");

    // A walk never runs with nothing left to visit
    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left != '0))
        else $error("walk active with zero steps left");

    // Dump of a non-empty list starts a walk
    a_dump_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_DUMP && !w_empty) |=> (r_state == S_WALK))
        else $error("dump did not start a walk");
`endif

endmodule
